// ===== rtl/brf_pkg.sv =====
// brf_pkg: shared constants, codes and controller/datapath interface types
// for the bisection root finder. No dependencies.
`timescale 1ns / 1ps

package brf_pkg;

  // fixed field widths
  localparam int XW         = 24;   // Q7.16 point width
  localparam int MW         = 47;   // polynomial magnitude width (saturation bound)
  localparam int SPLIT      = 24;   // magnitude split point for the partial products
  localparam int ROOT_SLOTS = 8;    // roots held in the packed register
  localparam int RIW        = 3;    // root slot index width
  localparam int MAX_ROOTS  = 8;    // root count clamp

  // parameter defaults
  localparam int MAX_ITER_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_ROOTS = 2'd0;
  localparam logic [1:0] CFG_COUNT = 2'd1;
  localparam logic [1:0] CFG_SCALE = 2'd2;
  localparam logic [1:0] CFG_TOL   = 2'd3;

  // reset values of the configuration registers
  localparam logic [31:0] ROOTS_RST = 32'd0;
  localparam logic [3:0]  COUNT_RST = 4'd1;
  localparam logic [3:0]  SCALE_RST = 4'd1;
  localparam logic [15:0] TOL_RST   = 16'd66;

  // result status codes
  localparam logic [1:0] ST_CONV   = 2'd0;
  localparam logic [1:0] ST_NOSIGN = 2'd1;
  localparam logic [1:0] ST_LIMIT  = 2'd2;

  typedef struct packed {
    logic       load;      // take a new interval
    logic       mid;       // p = floor((a+b)/2), x = p
    logic       ev_start;  // start polynomial evaluation at x
    logic       mul_lo;    // low partial product
    logic       mul_hi;    // high partial product
    logic       acc;       // fold product into magnitude, next root
    logic       scale;     // apply leading multiplier
    logic       save_fp;
    logic       save_fa;
    logic       save_fb;
    logic       x_a;
    logic       x_b;
    logic       inc_n;
    logic       take_a;    // a = p
    logic       take_b;    // b = p
    logic       set_stat;
    logic [1:0] stat;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_small;
    logic fp_pos;
    logic fp_neg;
    logic fa_pos;
    logic fa_neg;
    logic fb_pos;
    logic fb_neg;
    logic ends_ok;   // f(a), f(b) signs are known for this item
    logic last_root;
    logic no_roots;
    logic at_limit;
  } dp_stat_t;

endpackage

// ===== rtl/brf_dpath.sv =====
// brf_dpath: interval registers, polynomial evaluator whose partial products
// share one multiplier, sign cache and result register. Depends on brf_pkg.
`timescale 1ns / 1ps

module brf_dpath #(
  parameter int FRAC_BITS = brf_pkg::FRAC_BITS_DEF,
  parameter int MAX_ITER  = brf_pkg::MAX_ITER_DEF
) (
  input  logic                          clk,
  input  brf_pkg::dp_cmd_t              cmd,
  output brf_pkg::dp_stat_t             st,
  input  logic [31:0]                   roots_packed,
  input  logic [3:0]                    root_count,
  input  logic signed [3:0]             scale_factor,
  input  logic [15:0]                   tolerance,
  input  logic signed [brf_pkg::XW-1:0] interval_start,
  input  logic signed [brf_pkg::XW-1:0] interval_end,
  output logic signed [brf_pkg::XW-1:0] root_estimate,
  output logic [5:0]                    iterations,
  output logic [1:0]                    status
);
  import brf_pkg::*;

  localparam int DW  = ((FRAC_BITS + 4 > XW) ? FRAC_BITS + 4 : XW) + 1;
  localparam int DMW = DW - 1;
  localparam int PW  = SPLIT + DMW;
  localparam int RW  = PW + 1;
  localparam int SW  = MW + 4;
  localparam int NW  = $clog2(MAX_ITER + 1);
  localparam int SH  = SPLIT - FRAC_BITS;
  localparam logic [MW-1:0] SAT    = {MW{1'b1}};
  localparam logic [PW-1:0] AH_LIM = PW'(SAT >> SH);
  localparam logic [MW-1:0] ONE    = MW'(1) << FRAC_BITS;

  logic signed [XW-1:0] a_r, b_r, p_r, x_r;
  logic [MW-1:0]        mag_r;
  logic                 neg_r;
  logic [DMW-1:0]       dm_r;
  logic                 dneg_r;
  logic [RIW-1:0]       idx_r;
  logic [PW-1:0]        bl_r, ah_r;
  logic [NW-1:0]        n_r;
  logic                 fp_pos_r, fp_neg_r, fa_pos_r, fa_neg_r, fb_pos_r, fb_neg_r;
  logic                 ends_ok_r;
  logic [1:0]           stat_r;
  logic signed [XW-1:0] est_r;
  logic [5:0]           iter_r;
  logic [1:0]           status_r;

  logic [RIW-1:0]       ridx;
  logic signed [3:0]    root_v;
  logic signed [DW-1:0] d;
  logic [DMW-1:0]       d_mag;
  logic [SPLIT-1:0]     mul_a;
  logic [PW-1:0]        prod;
  logic [RW-1:0]        rsum;
  logic [MW-1:0]        mul_mag;
  logic [3:0]           sm;
  logic [SW-1:0]        scaled;
  logic [MW-1:0]        scaled_sat;
  logic [3:0]           cnt;
  logic signed [XW:0]   s;
  logic signed [XW-1:0] mid;
  logic [NW+5:0]        n_ext;

  // distance from x to the selected root, as magnitude and sign
  assign ridx   = cmd.ev_start ? '0 : idx_r + 1'b1;
  assign root_v = roots_packed[{ridx, 2'b00} +: 4];
  assign d      = DW'(x_r) - (DW'(root_v) <<< FRAC_BITS);
  assign d_mag  = d[DW-1] ? DMW'(-d) : DMW'(d);

  // shared multiplier: low or high slice of the magnitude times distance
  assign mul_a = cmd.mul_hi ? SPLIT'(mag_r[MW-1:SPLIT]) : mag_r[SPLIT-1:0];
  assign prod  = PW'(mul_a) * PW'(dm_r);

  // (mag * d) >> FRAC_BITS, saturated
  assign rsum    = (RW'(ah_r) << SH) + RW'(bl_r >> FRAC_BITS);
  assign mul_mag = (ah_r > AH_LIM || rsum > RW'(SAT)) ? SAT : rsum[MW-1:0];

  assign sm         = scale_factor[3] ? 4'(-scale_factor) : 4'(scale_factor);
  assign scaled     = SW'(mag_r) * SW'(sm);
  assign scaled_sat = (scaled > SW'(SAT)) ? SAT : scaled[MW-1:0];

  assign cnt = (root_count > 4'(MAX_ROOTS)) ? 4'(MAX_ROOTS) : root_count;

  assign s   = {a_r[XW-1], a_r} + {b_r[XW-1], b_r};
  assign mid = s[XW:1];

  assign n_ext = {6'd0, n_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r       <= interval_start;
      b_r       <= interval_end;
      n_r       <= '0;
      ends_ok_r <= 1'b0;
    end
    if (cmd.mid) begin
      p_r <= mid;
      x_r <= mid;
    end
    if (cmd.x_a) x_r <= a_r;
    if (cmd.x_b) x_r <= b_r;
    if (cmd.ev_start) begin
      mag_r  <= ONE;
      neg_r  <= 1'b0;
      idx_r  <= '0;
      dm_r   <= d_mag;
      dneg_r <= d[DW-1];
    end
    if (cmd.mul_lo) bl_r <= prod;
    if (cmd.mul_hi) ah_r <= prod;
    if (cmd.acc) begin
      mag_r  <= mul_mag;
      neg_r  <= neg_r ^ dneg_r;
      idx_r  <= idx_r + 1'b1;
      dm_r   <= d_mag;
      dneg_r <= d[DW-1];
    end
    if (cmd.scale) begin
      mag_r <= scaled_sat;
      neg_r <= neg_r ^ scale_factor[3];
    end
    if (cmd.save_fp) begin
      fp_pos_r <= (mag_r != '0) && !neg_r;
      fp_neg_r <= (mag_r != '0) && neg_r;
    end
    if (cmd.save_fa) begin
      fa_pos_r <= (mag_r != '0) && !neg_r;
      fa_neg_r <= (mag_r != '0) && neg_r;
    end
    if (cmd.save_fb) begin
      fb_pos_r  <= (mag_r != '0) && !neg_r;
      fb_neg_r  <= (mag_r != '0) && neg_r;
      ends_ok_r <= 1'b1;
    end
    if (cmd.inc_n) n_r <= n_r + 1'b1;
    // the moved end takes f(p), so its sign needs no new evaluation
    if (cmd.take_a) begin
      a_r      <= p_r;
      fa_pos_r <= fp_pos_r;
      fa_neg_r <= fp_neg_r;
    end
    if (cmd.take_b) begin
      b_r      <= p_r;
      fb_pos_r <= fp_pos_r;
      fb_neg_r <= fp_neg_r;
    end
    if (cmd.set_stat) stat_r <= cmd.stat;
    if (cmd.out_load) begin
      est_r    <= p_r;
      iter_r   <= n_ext[5:0];
      status_r <= stat_r;
    end
  end

  always_comb begin
    st.cur_small = (mag_r <= MW'(tolerance));
    st.fp_pos    = fp_pos_r;
    st.fp_neg    = fp_neg_r;
    st.fa_pos    = fa_pos_r;
    st.fa_neg    = fa_neg_r;
    st.fb_pos    = fb_pos_r;
    st.fb_neg    = fb_neg_r;
    st.ends_ok   = ends_ok_r;
    st.last_root = ((4'(idx_r) + 4'd1) == cnt);
    st.no_roots  = (cnt == 4'd0);
    st.at_limit  = (n_r == NW'(MAX_ITER));
  end

  assign root_estimate = est_r;
  assign iterations    = iter_r;
  assign status        = status_r;

endmodule

// ===== rtl/brf_ctrl.sv =====
// brf_ctrl: sequencer for the bisection rounds and the polynomial steps,
// plus input/output handshake. Depends on brf_pkg.
`timescale 1ns / 1ps

module brf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output brf_pkg::dp_cmd_t  cmd,
  input  brf_pkg::dp_stat_t st
);
  import brf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MID    = 10'b0000000010,
    S_EVST   = 10'b0000000100,
    S_MLO    = 10'b0000001000,
    S_MHI    = 10'b0000010000,
    S_ACC    = 10'b0000100000,
    S_SCALE  = 10'b0001000000,
    S_POST   = 10'b0010000000,
    S_DECIDE = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  // which value the running evaluation belongs to
  typedef enum logic [1:0] {
    TGT_P = 2'd0,
    TGT_A = 2'd1,
    TGT_B = 2'd2
  } tgt_t;

  state_t state_r, state_nxt;
  tgt_t   tgt_r, tgt_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    tgt_nxt       = tgt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        cmd.mid   = 1'b1;
        tgt_nxt   = TGT_P;
        state_nxt = S_EVST;
      end
      S_EVST: begin
        cmd.ev_start = 1'b1;
        state_nxt    = st.no_roots ? S_SCALE : S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = st.last_root ? S_SCALE : S_MLO;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_POST;
      end
      S_POST: begin
        case (tgt_r)
          TGT_P: begin
            cmd.save_fp = 1'b1;
            if (st.cur_small) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_CONV;
              state_nxt    = S_DONE;
            end else if (st.at_limit) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_LIMIT;
              state_nxt    = S_DONE;
            end else begin
              cmd.inc_n = 1'b1;
              if (st.ends_ok) begin
                state_nxt = S_DECIDE;
              end else begin
                cmd.x_a   = 1'b1;
                tgt_nxt   = TGT_A;
                state_nxt = S_EVST;
              end
            end
          end
          TGT_A: begin
            cmd.save_fa = 1'b1;
            cmd.x_b     = 1'b1;
            tgt_nxt     = TGT_B;
            state_nxt   = S_EVST;
          end
          TGT_B: begin
            cmd.save_fb = 1'b1;
            state_nxt   = S_DECIDE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DECIDE: begin
        state_nxt = S_MID;
        if (st.fp_pos && st.fa_neg) begin
          cmd.take_b = 1'b1;
        end else if (st.fp_pos && st.fb_neg) begin
          cmd.take_a = 1'b1;
        end else if (st.fp_neg && st.fa_pos) begin
          cmd.take_b = 1'b1;
        end else if (st.fp_neg && st.fb_pos) begin
          cmd.take_a = 1'b1;
        end else begin
          cmd.set_stat = 1'b1;
          cmd.stat     = ST_NOSIGN;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tgt_r       <= TGT_P;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgt_r       <= tgt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/bisection_root_finder.sv =====
// bisection_root_finder: top level with configuration registers, controller
// and datapath. Depends on brf_pkg, brf_ctrl, brf_dpath.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | interval_start, interval_end
//   out_    | output    | out_valid/out_stall| root_estimate, iterations, status
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item at a time. With k = min(root_count, 8), one polynomial evaluation
// is a start step, two partial products on the shared multiplier and a fold
// per root, then the scale step. Each round computes the midpoint, evaluates
// f(p) and decides which end moves; f(a) and f(b) are evaluated at most once
// per item and then tracked. A finished beat waits in the output register
// while the next item is taken. Synchronous active-low reset; cfg_ready is
// always high.
`timescale 1ns / 1ps

module bisection_root_finder #(
  parameter int FRAC_BITS = brf_pkg::FRAC_BITS_DEF,
  parameter int MAX_ITER  = brf_pkg::MAX_ITER_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [brf_pkg::XW-1:0] in_interval_start,
  input  logic signed [brf_pkg::XW-1:0] in_interval_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [brf_pkg::XW-1:0] out_root_estimate,
  output logic [5:0]                    out_iterations,
  output logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  import brf_pkg::*;

  logic [31:0]       roots_r;
  logic [3:0]        count_r;
  logic signed [3:0] scale_r;
  logic [15:0]       tol_r;
  dp_cmd_t           cmd;
  dp_stat_t          st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roots_r <= ROOTS_RST;
      count_r <= COUNT_RST;
      scale_r <= SCALE_RST;
      tol_r   <= TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROOTS: roots_r <= cfg_data;
        CFG_COUNT: count_r <= cfg_data[3:0];
        CFG_SCALE: scale_r <= cfg_data[3:0];
        CFG_TOL:   tol_r   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  brf_dpath #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_ITER  (MAX_ITER)
  ) u_dpath (
    .clk            (clk),
    .cmd            (cmd),
    .st             (st),
    .roots_packed   (roots_r),
    .root_count     (count_r),
    .scale_factor   (scale_r),
    .tolerance      (tol_r),
    .interval_start (in_interval_start),
    .interval_end   (in_interval_end),
    .root_estimate  (out_root_estimate),
    .iterations     (out_iterations),
    .status         (out_status)
  );

endmodule
